// ===== rtl/core/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// Tick task scheduler package
// Shared types and constants for the periodic task table.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int MaxTasks   = 16;
    localparam int SlotW      = 4;
    localparam int CountW     = 5;
    localparam int TagW       = 8;
    localparam int MsW        = 32;
    localparam int TickW      = 10;
    localparam int RunsW      = 8;
    localparam logic [RunsW-1:0] RunsLimit = 8'd255;
    localparam logic [TickW-1:0] TickReset = 10'd10;

    typedef enum logic [1:0] {
        ACT_TICK     = 2'd0,
        ACT_ADD      = 2'd1,
        ACT_DELETE   = 2'd2,
        ACT_DISPATCH = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_SLOT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_WALK,
        S_SHIFT,
        S_EMIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

endpackage

// ===== rtl/core/tts_div.sv =====
// ----------------------------------------------------------------------------
// Tick task scheduler divider
// Shared restoring divider, one quotient bit per cycle; divides two operands
// in turn (delay, then period) by the tick length.
// ----------------------------------------------------------------------------
module tts_div
    import tts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [MsW-1:0]   dividend,
    input  logic [TickW-1:0] divisor,
    output div_ctl_t         ctl,
    output logic [MsW-1:0]   quotient
);

    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [MsW-1:0]   quo_reg, quo_next;
    logic [TickW:0]   rem_reg, rem_next;
    logic [TickW-1:0] dvs_reg, dvs_next;
    logic [TickW+1:0] trial;
    logic [TickW:0]   shifted;

    always_comb
    begin
        shifted   = {rem_reg[TickW-1:0], quo_reg[MsW-1]};
        trial     = {1'b0, shifted} - {2'b00, dvs_reg};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = (divisor == '0) ? {{(TickW-1){1'b0}}, 1'b1} : divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[TickW+1])
            begin
                rem_next = trial[TickW:0];
                quo_next = {quo_reg[MsW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[MsW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(MsW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign quotient  = quo_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start) else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("done without busy");
    a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(done_reg && busy_reg)) else $error("done while busy");

endmodule

// ===== rtl/core/tick_task_scheduler_table.sv =====
// ----------------------------------------------------------------------------
// Tick task scheduler table
// Periodic task table with tick, add, delete and dispatch items.
// ----------------------------------------------------------------------------
// One item at a time. Tick walks the live slots, one slot per cycle. Add
// runs the shared bit-serial divider twice when not full. Delete shifts
// later slots down one slot per cycle. Dispatch visits one slot per cycle
// while the output is not stalled and sends each ready tag as its own
// result item; the block is not ready until the last result is taken.
module tick_task_scheduler_table
    import tts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[1:0], task_tag[9:2], delay_ms[41:10], period_ms[73:42],
    // slot_index[77:74], zero fill
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], task_valid[2], task_tag_res[10:3], task_count[15:11]
    output logic [15:0] m_tdata,
    output logic        m_tlast
);

    logic [TagW-1:0]  tag_mem    [MaxTasks];
    logic [MsW-1:0]   delay_mem  [MaxTasks];
    logic [MsW-1:0]   period_mem [MaxTasks];
    logic [RunsW-1:0] runs_mem   [MaxTasks];

    state_t           state_reg, state_next;
    logic [TickW-1:0] tick_reg;
    logic [CountW-1:0] live_reg, live_next;
    logic [CountW-1:0] idx_reg, idx_next;
    logic             phase_reg, phase_next;
    action_t          act_reg;
    logic [TagW-1:0]  tag_in_reg;
    logic [MsW-1:0]   dly_in_reg, per_in_reg, dly_q_reg;
    logic [SlotW-1:0] slot_in_reg;
    logic [CountW-1:0] sent_reg, sent_next;
    logic [1:0]       ost_reg;
    logic             ovalid_reg, otv_reg, olast_reg;
    logic [TagW-1:0]  otag_reg;

    logic             div_start;
    logic [MsW-1:0]   div_a, quo;
    div_ctl_t         dctl;
    logic [SlotW-1:0] idx;
    logic             ready_here, more_ready;
    logic             do_walk, do_shift, do_add, do_emit, out_load;
    logic [1:0]       ost_n;
    logic             otv_n, olast_n;
    logic [TagW-1:0]  otag_n;

    assign idx = idx_reg[SlotW-1:0];
    assign cfg_ready = (state_reg == S_IDLE);
    assign s_tready  = (state_reg == S_IDLE);
    assign div_a = phase_reg ? per_in_reg : dly_in_reg;

    tts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (tick_reg),
        .ctl      (dctl),
        .quotient (quo)
    );

    assign ready_here = (runs_mem[idx] != '0);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        live_next  = live_reg;
        sent_next  = sent_reg;
        div_start  = 1'b0;
        do_walk    = 1'b0;
        do_shift   = 1'b0;
        do_add     = 1'b0;
        do_emit    = 1'b0;
        out_load   = 1'b0;
        more_ready = 1'b0;
        ost_n      = ST_OK;
        otv_n      = 1'b0;
        otag_n     = '0;
        olast_n    = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    idx_next  = '0;
                    sent_next = '0;
                    case (action_t'(s_tdata[1:0]))
                        ACT_TICK:     state_next = S_WALK;
                        ACT_ADD:      state_next = S_DIV;
                        ACT_DELETE:   state_next = S_SHIFT;
                        ACT_DISPATCH: state_next = S_EMIT;
                        default:      state_next = S_IDLE;
                    endcase
                    if (action_t'(s_tdata[1:0]) == ACT_ADD)
                    begin
                        phase_next = 1'b0;
                        idx_next   = 5'd1;
                    end
                    if (action_t'(s_tdata[1:0]) == ACT_DELETE)
                        idx_next = {1'b0, s_tdata[77:74]};
                end
            end
            S_DIV:
            begin
                if (live_reg >= CountW'(MaxTasks))
                begin
                    ost_n      = ST_FULL;
                    out_load   = 1'b1;
                    state_next = S_OUT;
                end
                else if (idx_reg[0])
                begin
                    div_start = 1'b1;
                    idx_next  = '0;
                end
                else if (dctl.done)
                begin
                    if (!phase_reg)
                    begin
                        phase_next = 1'b1;
                        idx_next   = 5'd1;
                    end
                    else
                    begin
                        do_add     = 1'b1;
                        live_next  = live_reg + 5'd1;
                        out_load   = 1'b1;
                        state_next = S_OUT;
                    end
                end
            end
            S_WALK:
            begin
                if (idx_reg >= live_reg)
                begin
                    out_load   = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    do_walk  = 1'b1;
                    idx_next = idx_reg + 5'd1;
                end
            end
            S_SHIFT:
            begin
                if ({1'b0, slot_in_reg} >= live_reg)
                begin
                    ost_n      = ST_BAD_SLOT;
                    out_load   = 1'b1;
                    state_next = S_OUT;
                end
                else if (idx_reg + 5'd1 >= live_reg)
                begin
                    live_next  = live_reg - 5'd1;
                    out_load   = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    do_shift = 1'b1;
                    idx_next = idx_reg + 5'd1;
                end
            end
            S_EMIT:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    if (idx_reg >= live_reg || sent_reg == CountW'(MaxTasks))
                    begin
                        if (sent_reg == '0)
                        begin
                            out_load   = 1'b1;
                            state_next = S_OUT;
                        end
                        else
                            state_next = S_OUT;
                    end
                    else
                    begin
                        idx_next = idx_reg + 5'd1;
                        if (ready_here)
                        begin
                            do_emit   = 1'b1;
                            out_load  = 1'b1;
                            otv_n     = 1'b1;
                            otag_n    = tag_mem[idx];
                            sent_next = sent_reg + 5'd1;
                            more_ready = 1'b1;
                            olast_n   = 1'b0;
                        end
                    end
                end
            end
            S_OUT:
            begin
                if (!ovalid_reg || m_tready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Dispatch marks last on the final emitted item: search ahead for another.
    logic later_ready;
    always_comb
    begin
        later_ready = 1'b0;
        for (int k = 0; k < MaxTasks; k++)
        begin
            if (CountW'(k) > idx_reg && CountW'(k) < live_reg && runs_mem[k] != '0)
                later_ready = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            tick_reg   <= TickReset;
            live_reg   <= '0;
            idx_reg    <= '0;
            phase_reg  <= 1'b0;
            sent_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            live_reg  <= live_next;
            sent_reg  <= sent_next;
            if (cfg_valid && cfg_ready)
                tick_reg <= cfg_data;
            if (out_load)
                ovalid_reg <= 1'b1;
            else if (m_tready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            act_reg     <= action_t'(s_tdata[1:0]);
            tag_in_reg  <= s_tdata[9:2];
            dly_in_reg  <= s_tdata[41:10];
            per_in_reg  <= s_tdata[73:42];
            slot_in_reg <= s_tdata[77:74];
        end
        if (dctl.done && !phase_reg)
            dly_q_reg <= quo;
        if (out_load)
        begin
            ost_reg   <= ost_n;
            otv_reg   <= otv_n;
            otag_reg  <= otag_n;
            olast_reg <= more_ready
                ? !(later_ready && sent_reg + 5'd1 < CountW'(MaxTasks)) : olast_n;
        end
        if (do_add)
        begin
            tag_mem[live_reg[SlotW-1:0]]    <= tag_in_reg;
            delay_mem[live_reg[SlotW-1:0]]  <= dly_q_reg;
            period_mem[live_reg[SlotW-1:0]] <= quo;
            runs_mem[live_reg[SlotW-1:0]]   <= '0;
        end
        if (do_walk)
        begin
            if (delay_mem[idx] != '0)
                delay_mem[idx] <= delay_mem[idx] - 32'd1;
            else
            begin
                delay_mem[idx] <= period_mem[idx];
                if (runs_mem[idx] != RunsLimit)
                    runs_mem[idx] <= runs_mem[idx] + 8'd1;
            end
        end
        if (do_shift)
        begin
            tag_mem[idx]    <= tag_mem[idx + 4'd1];
            delay_mem[idx]  <= delay_mem[idx + 4'd1];
            period_mem[idx] <= period_mem[idx + 4'd1];
            runs_mem[idx]   <= runs_mem[idx + 4'd1];
        end
        if (do_emit)
            runs_mem[idx] <= runs_mem[idx] - 8'd1;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {live_reg, otag_reg, otv_reg, ost_reg};

    a_idle_no_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !out_load) else $error("result from idle");
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CountW'(MaxTasks)) else $error("live count overflow");
    a_div_only_add: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> act_reg == ACT_ADD) else $error("divider used off add");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !m_tready) |-> !out_load) else $error("result lost");

endmodule
